FILE: rtl/core/hcpp_pkg.sv
// hcpp_pkg: shared constants, types and the per-level curve step for the
// hilbert curve pixel plotter. No dependencies.
package hcpp_pkg;

	localparam int SIDE    = 256;
	localparam int LEVELS  = $clog2(SIDE);
	localparam int COORD_W = LEVELS;
	localparam int IDX_W   = 2 * LEVELS;
	localparam int ADDR_W  = 20;
	localparam int COLOR_W = 24;
	localparam int WIDTH_W = 13;
	localparam int POP_SHIFT = 13;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd256;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_COLOR_MODE    = 2'd1,
		REG_SCROLL_OFFSET = 2'd2,
		REG_FILE_SIZE     = 2'd3
	} reg_index_t;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [IDX_W-1:0]   index_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// one level of the d2xy walk: rotate or flip, then add the quadrant offset
	function automatic point_t hilbert_level(point_t p, logic [1:0] q, coord_t lvl);
		point_t r;
		logic   qx;
		logic   qy;
		coord_t tmp;
		qx = q[1];
		qy = q[0] ^ q[1];
		r  = p;
		if (!qy) begin
			if (qx) begin
				r.x = lvl - coord_t'(1) - p.x;
				r.y = lvl - coord_t'(1) - p.y;
			end
			tmp = r.x;
			r.x = r.y;
			r.y = tmp;
		end
		if (qx) begin
			r.x = r.x + lvl;
		end
		if (qy) begin
			r.y = r.y + lvl;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/hcpp_walk.sv
// hcpp_walk: pipelined d2xy walk, one register stage per curve level.
// Depends on hcpp_pkg.
module hcpp_walk (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  hcpp_pkg::index_t in_index,
	output logic            out_valid,
	output hcpp_pkg::point_t out_point
);
	import hcpp_pkg::*;

	logic   vld_s [LEVELS];
	point_t pt_s  [LEVELS];
	index_t idx_s [LEVELS];

	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		localparam coord_t LVL = coord_t'(1) << k;
		logic   vld_in;
		point_t pt_in;
		index_t idx_in;

		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign pt_in  = '0;
			assign idx_in = in_index;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign pt_in  = pt_s[k-1];
			assign idx_in = idx_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			pt_s[k]  <= hilbert_level(pt_in, idx_in[2*k +: 2], LVL);
			idx_s[k] <= idx_in;
		end
	end

	assign out_valid = vld_s[LEVELS-1];
	assign out_point = pt_s[LEVELS-1];

endmodule

FILE: rtl/core/hilbert_curve_pixel_plotter.sv
// hilbert_curve_pixel_plotter: top level, config registers, colour path and
// address stage. Depends on hcpp_pkg and hcpp_walk.
// Throughput: one item per cycle; busy stays low, the results cannot be stalled.
// The depth is set by the walk, one register stage per curve level, plus the output register.
// Reset: asynchronous, clears the pipeline valid bits and returns the config registers to their defaults.
module hilbert_curve_pixel_plotter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] curve_index,
	input  logic [7:0]  byte_value,
	output logic        done,
	output logic [7:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [19:0] pixel_address,
	output logic [23:0] pixel_color,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import hcpp_pkg::*;

	localparam int PROD_W = COORD_W + WIDTH_W + 1;

	logic [WIDTH_W-1:0] image_width_q;
	logic               color_mode_q;
	logic [31:0]        scroll_offset_q;
	logic [31:0]        file_size_q;

	logic               accept;
	logic               walk_valid;
	point_t             walk_point;
	logic [32:0]        pos;
	logic [3:0]         ones;
	logic [COLOR_W-1:0] color_c;
	logic [COLOR_W-1:0] color_s [LEVELS];
	logic [PROD_W-1:0]  addr_full;

	logic               done_sr;
	logic [7:0]         x_sr;
	logic [7:0]         y_sr;
	logic [ADDR_W-1:0]  addr_sr;
	logic [COLOR_W-1:0] color_sr;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= WIDTH_RESET;
			color_mode_q    <= 1'b0;
			scroll_offset_q <= '0;
			file_size_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data[WIDTH_W-1:0];
				REG_COLOR_MODE:    color_mode_q    <= cfg_data[0];
				REG_SCROLL_OFFSET: scroll_offset_q <= cfg_data;
				REG_FILE_SIZE:     file_size_q     <= cfg_data;
			endcase
		end
	end

	hcpp_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_index (index_t'(curve_index)),
		.out_valid(walk_valid),
		.out_point(walk_point)
	);

	// colour travels beside the walk
	always_comb begin
		pos  = 33'(curve_index) + 33'(scroll_offset_q);
		ones = 4'($countones(byte_value));
		if (pos >= {1'b0, file_size_q}) begin
			color_c = '0;
		end else if (color_mode_q) begin
			color_c = (COLOR_W'(ones) << POP_SHIFT) | COLOR_W'(byte_value);
		end else begin
			color_c = {byte_value, byte_value, byte_value};
		end
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_color
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				color_s[k] <= color_c;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				color_s[k] <= color_s[k-1];
			end
		end
	end

	assign addr_full = PROD_W'(walk_point.y) * PROD_W'(image_width_q)
		+ PROD_W'(walk_point.x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_sr <= 1'b0;
		end else begin
			done_sr <= walk_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_sr     <= 8'(walk_point.x);
		y_sr     <= 8'(walk_point.y);
		addr_sr  <= ADDR_W'(addr_full);
		color_sr <= color_s[LEVELS-1];
	end

	assign done          = done_sr;
	assign pixel_x       = x_sr;
	assign pixel_y       = y_sr;
	assign pixel_address = addr_sr;
	assign pixel_color   = color_sr;

	// gray mode replicates one byte into all channels
	a_gray_replicated: assert property (@(posedge clk) disable iff (!arst_n)
		done && !color_mode_q |->
			pixel_color[23:16] == pixel_color[7:0] && pixel_color[15:8] == pixel_color[7:0])
		else $error("gray colour channels differ");

	// popcount mode leaves the gap bits and the top bits clear
	a_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && color_mode_q |-> pixel_color[12:8] == 5'd0 && pixel_color[23:17] == 7'd0)
		else $error("popcount colour has stray bits");

	// a byte has at most eight ones
	a_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && color_mode_q |-> pixel_color[16:13] <= 4'd8)
		else $error("popcount out of range");

endmodule

FILE: verif/hilbert_curve_pixel_plotter_tb.sv
`timescale 1ns / 1ps
// hilbert_curve_pixel_plotter_tb: self-checking bench for the hilbert curve pixel plotter,
// with a queue-fed command driver, a result monitor and its own curve/color predictor.
// Depends on hcpp_pkg and the hilbert_curve_pixel_plotter rtl.
module hilbert_curve_pixel_plotter_tb;
	import hcpp_pkg::*;

	localparam int  LATENCY     = LEVELS + 1;
	localparam int  CYCLE_LIMIT = 400000;
	localparam int  RANDOM_SETS = 10;
	localparam int  SET_ITEMS   = 140;
	localparam logic COLOR_GRAY     = 1'b0;
	localparam logic COLOR_POPCOUNT = 1'b1;

	typedef struct {
		logic [15:0] index;
		logic [7:0]  data;
	} sample_t;

	typedef struct {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [19:0] addr;
		logic [23:0] color;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] curve_index = '0;
	logic [7:0]  byte_value = '0;
	logic        done;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [19:0] pixel_address;
	logic [23:0] pixel_color;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// register copies, as after reset
	logic [12:0] cur_width  = 13'd256;
	logic        cur_mode   = COLOR_GRAY;
	logic [31:0] cur_scroll = '0;
	logic [31:0] cur_fsize  = '0;

	sample_t pending_samples[$];
	pixel_t  expected_pixels[$];
	sample_t next_sample;
	bit      idle_enable = 1'b1;
	int      gap_left = 0;
	int      cycles = 0;
	int      checked = 0;
	int      errors = 0;
	int      settings = 0;

	hilbert_curve_pixel_plotter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.curve_index   (curve_index),
		.byte_value    (byte_value),
		.done          (done),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pixel_t plot_pixel(logic [15:0] distance, logic [7:0] data);
		pixel_t      p;
		int unsigned x;
		int unsigned y;
		int unsigned t;
		int unsigned lvl;
		int unsigned qx;
		int unsigned qy;
		int unsigned tmp;
		logic [63:0] addr;
		logic [32:0] pos;
		logic [3:0]  ones;
		x = 0;
		y = 0;
		t = distance;
		for (lvl = 1; lvl < SIDE; lvl = lvl << 1) begin
			qx = (t >> 1) & 1;
			qy = (t ^ qx) & 1;
			if (qy == 0) begin
				if (qx == 1) begin
					x = lvl - 1 - x;
					y = lvl - 1 - y;
				end
				tmp = x;
				x = y;
				y = tmp;
			end
			x = x + lvl * qx;
			y = y + lvl * qy;
			t = t >> 2;
		end
		addr = 64'(y) * 64'(cur_width) + 64'(x);
		pos = 33'(distance) + 33'(cur_scroll);
		ones = '0;
		for (int k = 0; k < 8; k++) begin
			ones = ones + 4'(data[k]);
		end
		p.x = x[7:0];
		p.y = y[7:0];
		p.addr = addr[19:0];
		if (pos >= 33'(cur_fsize)) begin
			p.color = '0;
		end else if (cur_mode == COLOR_POPCOUNT) begin
			p.color = (24'(ones) << POP_SHIFT) | 24'(data);
		end else begin
			p.color = {data, data, data};
		end
		return p;
	endfunction

	// command driver: one sample per transfer, random idle bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_samples.size() != 0 && idle_enable
					&& $urandom_range(0, 5) == 0) begin
				gap_left <= $urandom_range(0, 17);
				start <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				next_sample = pending_samples.pop_front();
				curve_index <= next_sample.index;
				byte_value <= next_sample.data;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_pixels.push_back(plot_pixel(curve_index, byte_value));
			end
			if (done) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result x=%0d y=%0d addr=%h color=%h",
							pixel_x, pixel_y, pixel_address, pixel_color);
					end
				end else begin
					pixel_t want;
					want = expected_pixels.pop_front();
					checked++;
					if (pixel_x !== want.x || pixel_y !== want.y
							|| pixel_address !== want.addr || pixel_color !== want.color) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected x=%0d y=%0d addr=%h color=%h",
								want.x, want.y, want.addr, want.color);
							$display("          actual   x=%0d y=%0d addr=%h color=%h",
								pixel_x, pixel_y, pixel_address, pixel_color);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_samples.size() != 0 || start || expected_pixels.size() != 0);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:   cur_width = data[12:0];
			REG_COLOR_MODE:    cur_mode = data[0];
			REG_SCROLL_OFFSET: cur_scroll = data;
			REG_FILE_SIZE:     cur_fsize = data;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [12:0] width, logic mode, logic [31:0] scroll,
			logic [31:0] fsize);
		logic [31:0] noise;
		wait_idle();
		repeat (LATENCY + 2) @(posedge clk);
		noise = $urandom;
		write_reg(REG_IMAGE_WIDTH, {noise[31:13], width});
		noise = $urandom;
		write_reg(REG_COLOR_MODE, {noise[31:1], mode});
		write_reg(REG_SCROLL_OFFSET, scroll);
		write_reg(REG_FILE_SIZE, fsize);
		settings++;
	endtask

	task automatic add_sample(logic [15:0] idx, logic [7:0] data);
		sample_t s;
		s.index = idx;
		s.data = data;
		pending_samples.push_back(s);
	endtask

	task automatic random_setting();
		logic [12:0] width;
		logic [31:0] scroll;
		logic [31:0] fsize;
		longint      sum;
		case ($urandom_range(0, 5))
			0: width = 13'd256;
			1: width = 13'd4096;
			2: width = 13'd0;
			3: width = 13'h1fff;
			4: width = 13'($urandom_range(256, 4096));
			default: width = 13'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: scroll = '0;
			1: scroll = $urandom_range(0, 70000);
			2: scroll = 32'hffff_ffff;
			default: scroll = $urandom;
		endcase
		sum = longint'(scroll) + longint'($urandom_range(0, 65536));
		case ($urandom_range(0, 4))
			0: fsize = '0;
			1: fsize = 32'hffff_ffff;
			2: fsize = $urandom;
			default: fsize = (sum > 64'hffff_ffff) ? 32'hffff_ffff : sum[31:0];
		endcase
		set_config(width, 1'($urandom), scroll, fsize);
	endtask

	task automatic random_samples(int count);
		longint      span;
		logic [15:0] idx;
		for (int n = 0; n < count; n++) begin
			span = longint'(cur_fsize) - longint'(cur_scroll);
			idx = 16'($urandom);
			// aim at the end-of-file edge now and then
			if ($urandom_range(0, 3) == 0 && span >= 1 && span <= 65535) begin
				idx = 16'(span - 1 + $urandom_range(0, 1));
			end
			add_sample(idx, 8'($urandom));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty file, every color zero
		add_sample(16'h0000, 8'hff);
		add_sample(16'hffff, 8'hff);
		add_sample(16'h5555, 8'h00);
		add_sample(16'haaaa, 8'ha5);

		set_config(13'd256, COLOR_GRAY, 32'd0, 32'd65536);
		add_sample(16'h0000, 8'h00);
		add_sample(16'hffff, 8'hff);
		add_sample(16'h0001, 8'h80);
		add_sample(16'h0002, 8'h01);
		add_sample(16'h0003, 8'haa);
		add_sample(16'h8000, 8'h55);
		add_sample(16'h7fff, 8'h0f);
		add_sample(16'h1234, 8'hf0);

		set_config(13'd4096, COLOR_POPCOUNT, 32'd0, 32'd100);
		add_sample(16'd98, 8'hff);
		add_sample(16'd99, 8'h00);
		add_sample(16'd100, 8'hff);
		add_sample(16'hffff, 8'h7e);
		add_sample(16'h5555, 8'h81);

		// width beyond the frame buffer wraps the address; sum past 32 bits does not wrap
		set_config(13'h1fff, COLOR_POPCOUNT, 32'hffff_ffff, 32'hffff_ffff);
		add_sample(16'h0000, 8'hff);
		add_sample(16'hffff, 8'hff);
		add_sample(16'haaaa, 8'h3c);

		set_config(13'd0, COLOR_GRAY, 32'hffff_fff0, 32'hffff_ffff);
		add_sample(16'd14, 8'hc3);
		add_sample(16'd15, 8'hc3);

		for (int s = 0; s < RANDOM_SETS; s++) begin
			random_setting();
			if (s == RANDOM_SETS - 1) begin
				idle_enable = 1'b0;
			end
			random_samples(SET_ITEMS);
		end

		wait_idle();
		repeat (2 * LATENCY + 4) @(posedge clk);
		$display("%0d pixels checked over %0d register settings plus reset values", checked,
			settings);
		$display("covered both color modes, widths 0 to 8191 and end-of-file cutoffs");
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
